// ===== design/trdt_pkg.sv =====
// Package: shared types, constants and opcodes for the tile residency tracker.
`default_nettype none
package trdt_pkg;
    localparam int GRID_TILES_DEF = 1024;
    localparam int STAMP_BITS_DEF = 32;

    localparam logic [3:0] K_ACCESS        = 4'd0;
    localparam logic [3:0] K_LOCK          = 4'd1;
    localparam logic [3:0] K_MARK_DIRTY    = 4'd2;
    localparam logic [3:0] K_CLEAR_DIRTY   = 4'd3;
    localparam logic [3:0] K_QUERY_DIRTY   = 4'd4;
    localparam logic [3:0] K_RESTORE_EMPTY = 4'd5;
    localparam logic [3:0] K_RESTORE_FULL  = 4'd6;
    localparam logic [3:0] K_CLEAR_ALL     = 4'd7;
    localparam logic [3:0] K_MARK_ALL      = 4'd8;
    localparam logic [3:0] K_CLEAR_ALL_D   = 4'd9;
    localparam logic [3:0] K_QUERY_RES     = 4'd10;

    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RES_LIMIT   = 2'd2;

    typedef struct packed {
        logic [3:0] kind;
        logic [4:0] tile_col;
        logic [4:0] tile_row;
    } t_req;

    typedef struct packed {
        logic       status;
        logic       was_resident;
        logic       did_evict;
        logic [4:0] victim_col;
        logic [4:0] victim_row;
        logic       answer;
    } t_rsp;
endpackage
`default_nettype wire

// ===== design/tile_residency_dirty_tracker_core.sv =====
// Tile residency / dirty tracker: per-tile flags, LRU clean-first eviction scan.
// Flow: a taken request goes S_LOOK, S_APPLY, S_RESP; an eviction adds an S_SCAN pass
// (one tile per cycle, stamp reads for resident tiles), S_DRAIN, S_SETTLE and a second
// S_APPLY; whole-grid kinds (clear all, mark all dirty, clear all dirty) use S_WALL.
// Requests: one at a time; the next is taken only after the response handoff.
// Reset: sync active low; clears flags and counters, loads default config, keeps stamps.
`default_nettype none
module tile_residency_dirty_tracker_core #(
    parameter int GRID_TILES = trdt_pkg::GRID_TILES_DEF,
    parameter int STAMP_BITS = trdt_pkg::STAMP_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  trdt_pkg::t_req      i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output trdt_pkg::t_rsp      o_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [10:0]         i_cfg_data
);
    localparam int IW = $clog2(GRID_TILES);
    localparam int CW = $clog2(GRID_TILES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_SCAN, S_DRAIN, S_SETTLE, S_APPLY, S_WALL, S_RESP
    } t_state;

    t_state              r_state;
    logic [GRID_TILES-1:0] r_res, r_dirty, r_pend;
    logic [STAMP_BITS-1:0] r_stamps [GRID_TILES];
    logic [STAMP_BITS-1:0] r_ctr;
    logic [CW-1:0]       r_count;
    logic                r_raised;
    logic [5:0]          r_gw, r_gh;
    logic [10:0]         r_limit;
    trdt_pkg::t_req      r_req;
    trdt_pkg::t_rsp      r_rsp;
    logic [IW-1:0]       r_idx;
    logic [CW-1:0]       r_scan;
    logic [5:0]          r_sc_col;
    logic [4:0]          r_sc_row;
    logic [IW-1:0]       r_rd_i;
    logic                r_rd_v, r_rd_d;
    logic [4:0]          r_rd_col, r_rd_row;
    logic [STAMP_BITS-1:0] r_rd_s;
    logic                r_hc, r_ha;
    logic [IW-1:0]       r_ci, r_ai;
    logic [4:0]          r_ccol, r_crow, r_acol, r_arow;
    logic [STAMP_BITS-1:0] r_cs, r_as;
    logic [12:0]         r_tiles;
    logic                r_oor;

    logic [10:0]         prod;
    logic [12:0]         cap;
    logic [IW-1:0]       vic;
    logic [4:0]          vcol, vrow;
    logic                evict_go;

    assign o_stall     = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_RESP);
    assign o_data      = r_rsp;

    assign prod = 11'(r_gw * r_req.tile_row) + 11'(r_req.tile_col);

    always_comb begin
        cap = 13'(r_limit);
        if ((r_raised || r_req.kind == trdt_pkg::K_RESTORE_FULL) && r_tiles > cap) begin
            cap = r_tiles;
        end
    end

    assign evict_go = (r_req.kind == trdt_pkg::K_ACCESS || r_req.kind == trdt_pkg::K_LOCK ||
                       r_req.kind == trdt_pkg::K_RESTORE_FULL) &&
                      !r_oor && !r_res[r_idx] && !r_ha &&
                      (13'(r_count) >= cap) && (r_count != '0);

    assign vic  = r_hc ? r_ci : r_ai;
    assign vcol = r_hc ? r_ccol : r_acol;
    assign vrow = r_hc ? r_crow : r_arow;

    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_rd_s <= r_stamps[r_rd_i];
        end
        if (r_state == S_APPLY && !r_oor && (r_req.kind == trdt_pkg::K_ACCESS ||
            r_req.kind == trdt_pkg::K_LOCK || r_req.kind == trdt_pkg::K_RESTORE_FULL)) begin
            r_stamps[r_idx] <= (r_ctr == {STAMP_BITS{1'b1}}) ? r_ctr
                                                            : r_ctr + STAMP_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_res    <= '0;
            r_dirty  <= '0;
            r_pend   <= '0;
            r_ctr    <= '0;
            r_count  <= '0;
            r_raised <= 1'b0;
            r_gw     <= 6'd32;
            r_gh     <= 6'd32;
            r_limit  <= 11'd1024;
            r_rd_v   <= 1'b0;
        end else begin
            r_rd_v <= (r_state == S_SCAN) && r_res[r_scan[IW-1:0]];
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        unique case (i_cfg_index)
                            trdt_pkg::CFG_GRID_WIDTH:  r_gw <= i_cfg_data[5:0];
                            trdt_pkg::CFG_GRID_HEIGHT: r_gh <= i_cfg_data[5:0];
                            trdt_pkg::CFG_RES_LIMIT:   r_limit <= i_cfg_data;
                            default: ;
                        endcase
                    end else if (i_valid) begin
                        r_req   <= i_data;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_tiles <= (13'(r_gw * r_gh) > 13'(GRID_TILES)) ? 13'(GRID_TILES)
                                                                  : 13'(r_gw * r_gh);
                    r_oor   <= ({1'b0, r_req.tile_col} >= r_gw) ||
                               ({1'b0, r_req.tile_row} >= r_gh) ||
                               (32'(prod) >= 32'(GRID_TILES));
                    r_idx    <= IW'(prod);
                    r_rsp    <= '0;
                    r_scan   <= '0;
                    r_sc_col <= '0;
                    r_sc_row <= '0;
                    r_state  <= (r_req.kind == trdt_pkg::K_CLEAR_ALL ||
                                 r_req.kind == trdt_pkg::K_MARK_ALL ||
                                 r_req.kind == trdt_pkg::K_CLEAR_ALL_D) ? S_WALL : S_APPLY;
                end
                S_APPLY: begin
                    r_state <= evict_go ? S_SCAN : S_RESP;
                    if (r_req.kind > trdt_pkg::K_QUERY_RES) begin
                        r_rsp <= '0;
                    end else if (r_oor) begin
                        r_rsp.status <= 1'b1;
                    end else begin
                        r_rsp.was_resident <= r_res[r_idx];
                        case (r_req.kind)
                            trdt_pkg::K_ACCESS, trdt_pkg::K_LOCK,
                            trdt_pkg::K_RESTORE_FULL: begin
                                if (!evict_go) begin
                                    if (r_ctr != {STAMP_BITS{1'b1}}) begin
                                        r_ctr <= r_ctr + STAMP_BITS'(1);
                                    end
                                    if (r_ha) begin
                                        r_res[vic]   <= 1'b0;
                                        r_dirty[vic] <= 1'b0;
                                        r_pend[vic]  <= 1'b1;
                                        r_rsp.did_evict  <= 1'b1;
                                        r_rsp.victim_col <= vcol;
                                        r_rsp.victim_row <= vrow;
                                    end
                                    if (!r_res[r_idx]) begin
                                        r_res[r_idx] <= 1'b1;
                                        r_count <= r_count + (r_ha ? CW'(0) : CW'(1));
                                    end
                                    if (r_req.kind == trdt_pkg::K_LOCK ||
                                        r_req.kind == trdt_pkg::K_RESTORE_FULL) begin
                                        r_dirty[r_idx] <= 1'b1;
                                        r_pend[r_idx]  <= 1'b0;
                                    end else if (!r_res[r_idx]) begin
                                        r_dirty[r_idx] <= 1'b0;
                                        r_pend[r_idx]  <= 1'b0;
                                    end
                                    if (r_req.kind == trdt_pkg::K_RESTORE_FULL) begin
                                        r_raised <= 1'b1;
                                    end
                                end
                            end
                            trdt_pkg::K_MARK_DIRTY: begin
                                if (r_res[r_idx]) begin
                                    r_dirty[r_idx] <= 1'b1;
                                    r_pend[r_idx]  <= 1'b0;
                                end else begin
                                    r_pend[r_idx] <= 1'b1;
                                end
                            end
                            trdt_pkg::K_CLEAR_DIRTY: begin
                                if (r_res[r_idx]) r_dirty[r_idx] <= 1'b0;
                                r_pend[r_idx] <= 1'b0;
                            end
                            trdt_pkg::K_QUERY_DIRTY: begin
                                r_rsp.answer <= r_pend[r_idx] |
                                                (r_res[r_idx] & r_dirty[r_idx]);
                            end
                            trdt_pkg::K_RESTORE_EMPTY: begin
                                if (r_res[r_idx]) begin
                                    r_res[r_idx] <= 1'b0;
                                    r_count <= r_count - CW'(1);
                                end
                                r_dirty[r_idx] <= 1'b0;
                                r_pend[r_idx]  <= 1'b1;
                            end
                            default: begin
                                r_rsp.answer <= r_res[r_idx];
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // visit one tile per cycle, issuing a stamp read for a resident one; compare previous read
                    r_rd_i   <= r_scan[IW-1:0];
                    r_rd_d   <= r_dirty[r_scan[IW-1:0]];
                    r_rd_col <= r_sc_col[4:0];
                    r_rd_row <= r_sc_row;
                    r_scan   <= r_scan + CW'(1);
                    if (r_sc_col + 6'd1 == r_gw) begin
                        r_sc_col <= '0;
                        r_sc_row <= r_sc_row + 5'd1;
                    end else begin
                        r_sc_col <= r_sc_col + 6'd1;
                    end
                    if (r_scan == CW'(GRID_TILES - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_SETTLE;
                end
                S_SETTLE: begin
                    r_state <= S_APPLY;
                end
                S_WALL: begin
                    r_scan <= r_scan + CW'(1);
                    if (r_scan == CW'(GRID_TILES - 1)) begin
                        r_state <= S_RESP;
                        if (r_req.kind == trdt_pkg::K_CLEAR_ALL) begin
                            r_count <= '0;
                            r_ctr   <= '0;
                        end
                    end
                    case (r_req.kind)
                        trdt_pkg::K_CLEAR_ALL: begin
                            if (r_res[r_scan[IW-1:0]]) r_pend[r_scan[IW-1:0]] <= 1'b1;
                            r_res[r_scan[IW-1:0]]   <= 1'b0;
                            r_dirty[r_scan[IW-1:0]] <= 1'b0;
                        end
                        trdt_pkg::K_MARK_ALL: begin
                            if (r_res[r_scan[IW-1:0]]) r_dirty[r_scan[IW-1:0]] <= 1'b1;
                        end
                        default: begin
                            r_dirty[r_scan[IW-1:0]] <= 1'b0;
                            r_pend[r_scan[IW-1:0]]  <= 1'b0;
                        end
                    endcase
                end
                S_RESP: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // comparators (clean and any): consume registered stamp reads in the cycle after issue
    logic r_cmp_v;
    logic r_cmp_d;
    logic [IW-1:0] r_cmp_i;
    logic [4:0] r_cmp_col, r_cmp_row;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_v <= 1'b0;
        end else begin
            r_cmp_v   <= r_rd_v;
            r_cmp_d   <= r_rd_d;
            r_cmp_i   <= r_rd_i;
            r_cmp_col <= r_rd_col;
            r_cmp_row <= r_rd_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK) begin
            r_hc <= 1'b0;
            r_ha <= 1'b0;
            r_ci <= '0;
            r_ai <= '0;
        end else if (r_cmp_v) begin
            if (!r_cmp_d && (!r_hc || r_rd_s < r_cs)) begin
                r_hc   <= 1'b1;
                r_cs   <= r_rd_s;
                r_ci   <= r_cmp_i;
                r_ccol <= r_cmp_col;
                r_crow <= r_cmp_row;
            end
            if (!r_ha || r_rd_s < r_as) begin
                r_ha   <= 1'b1;
                r_as   <= r_rd_s;
                r_ai   <= r_cmp_i;
                r_acol <= r_cmp_col;
                r_arow <= r_cmp_row;
            end
        end
    end

`ifndef ASSERT_OFF
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("response dropped");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("request taken while busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= GRID_TILES) else $error("resident count overflow");
`endif
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the tile residency and dirty tracker core.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILES = 1024;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    trdt_pkg::t_req i_data = '0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    trdt_pkg::t_rsp o_data;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index = '0;
    logic [10:0]    i_cfg_data = '0;

    tile_residency_dirty_tracker_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    bit          tile_res [TILES];
    bit          tile_dirty [TILES];
    bit          tile_pend [TILES];
    logic [31:0] tile_stamp [TILES];
    logic [31:0] stamp_ctr;
    int unsigned res_count;
    bit          cap_raised;
    int unsigned cfg_w = 32, cfg_h = 32, cfg_lim = 1024;

    trdt_pkg::t_rsp exp_rsp_q[$];
    int   err_count = 0;
    int   gap_pct = 0;
    int   stall_pct = 0;
    int   hold_left = 0;

    function automatic logic [31:0] bump_stamp();
        if (stamp_ctr != 32'hFFFF_FFFF) stamp_ctr = stamp_ctr + 1;
        return stamp_ctr;
    endfunction

    function automatic int unsigned capacity_now();
        int unsigned cap, tiles;
        cap = cfg_lim;
        if (cap_raised) begin
            tiles = cfg_w * cfg_h;
            if (tiles > TILES) tiles = TILES;
            if (tiles > cap) cap = tiles;
        end
        return cap;
    endfunction

    function automatic bit evict_lru(output int unsigned victim);
        bit have_clean, have_any;
        int unsigned clean_i, any_i;
        logic [31:0] clean_s, any_s;
        have_clean = 0; have_any = 0; clean_i = 0; any_i = 0;
        clean_s = '0; any_s = '0; victim = 0;
        for (int i = 0; i < TILES; i++) begin
            if (tile_res[i]) begin
                if (!tile_dirty[i] && (!have_clean || tile_stamp[i] < clean_s)) begin
                    have_clean = 1; clean_s = tile_stamp[i]; clean_i = i;
                end
                if (!have_any || tile_stamp[i] < any_s) begin
                    have_any = 1; any_s = tile_stamp[i]; any_i = i;
                end
            end
        end
        if (!have_any) return 0;
        victim = have_clean ? clean_i : any_i;
        tile_res[victim] = 0;
        tile_dirty[victim] = 0;
        tile_pend[victim] = 1;
        res_count--;
        return 1;
    endfunction

    function automatic bit place_tile(int unsigned idx, output int unsigned victim);
        bit ev;
        ev = 0; victim = 0;
        if (tile_res[idx]) return 0;
        if (res_count >= capacity_now()) ev = evict_lru(victim);
        tile_res[idx] = 1;
        res_count++;
        return ev;
    endfunction

    function automatic trdt_pkg::t_rsp predict_rsp(trdt_pkg::t_req r);
        trdt_pkg::t_rsp o;
        int unsigned idx, victim;
        bit ev, was;
        o = '0; ev = 0; victim = 0;
        if (r.kind > trdt_pkg::K_QUERY_RES) return o;
        if (r.kind == trdt_pkg::K_CLEAR_ALL) begin
            for (int i = 0; i < TILES; i++) begin
                if (tile_res[i]) tile_pend[i] = 1;
                tile_res[i] = 0;
                tile_dirty[i] = 0;
            end
            res_count = 0;
            stamp_ctr = '0;
            return o;
        end
        if (r.kind == trdt_pkg::K_MARK_ALL) begin
            for (int i = 0; i < TILES; i++) if (tile_res[i]) tile_dirty[i] = 1;
            return o;
        end
        if (r.kind == trdt_pkg::K_CLEAR_ALL_D) begin
            for (int i = 0; i < TILES; i++) begin
                tile_dirty[i] = 0;
                tile_pend[i] = 0;
            end
            return o;
        end
        idx = r.tile_row * cfg_w + r.tile_col;
        if (r.tile_col >= cfg_w || r.tile_row >= cfg_h || idx >= TILES) begin
            o.status = 1'b1;
            return o;
        end
        was = tile_res[idx];
        case (r.kind)
            trdt_pkg::K_ACCESS, trdt_pkg::K_LOCK: begin
                if (!was) begin
                    ev = place_tile(idx, victim);
                    tile_dirty[idx] = 0;
                    tile_pend[idx] = 0;
                end
                tile_stamp[idx] = bump_stamp();
                if (r.kind == trdt_pkg::K_LOCK) begin
                    tile_dirty[idx] = 1;
                    tile_pend[idx] = 0;
                end
            end
            trdt_pkg::K_MARK_DIRTY: begin
                if (was) begin
                    tile_dirty[idx] = 1;
                    tile_pend[idx] = 0;
                end else begin
                    tile_pend[idx] = 1;
                end
            end
            trdt_pkg::K_CLEAR_DIRTY: begin
                if (was) tile_dirty[idx] = 0;
                tile_pend[idx] = 0;
            end
            trdt_pkg::K_QUERY_DIRTY: o.answer = tile_pend[idx] || (was && tile_dirty[idx]);
            trdt_pkg::K_RESTORE_EMPTY: begin
                if (was) begin
                    tile_res[idx] = 0;
                    res_count--;
                end
                tile_dirty[idx] = 0;
                tile_pend[idx] = 1;
            end
            trdt_pkg::K_RESTORE_FULL: begin
                tile_pend[idx] = 0;
                cap_raised = 1;
                ev = place_tile(idx, victim);
                tile_dirty[idx] = 1;
                tile_stamp[idx] = bump_stamp();
            end
            default: o.answer = was;
        endcase
        o.was_resident = was;
        if (ev) begin
            o.did_evict = 1'b1;
            o.victim_col = 5'((victim % cfg_w) & 32'h1F);
            o.victim_row = 5'((victim / cfg_w) & 32'h1F);
        end
        return o;
    endfunction

    task automatic check_rsp(trdt_pkg::t_rsp got);
        trdt_pkg::t_rsp want;
        if (exp_rsp_q.size() == 0) begin
            $error("unexpected response %h", got);
            err_count++;
            return;
        end
        want = exp_rsp_q.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, got.status);
            err_count++;
        end
        if (got.was_resident !== want.was_resident) begin
            $error("was_resident: expected %0d actual %0d", want.was_resident, got.was_resident);
            err_count++;
        end
        if (got.did_evict !== want.did_evict) begin
            $error("did_evict: expected %0d actual %0d", want.did_evict, got.did_evict);
            err_count++;
        end
        if (got.victim_col !== want.victim_col) begin
            $error("victim_col: expected %0d actual %0d", want.victim_col, got.victim_col);
            err_count++;
        end
        if (got.victim_row !== want.victim_row) begin
            $error("victim_row: expected %0d actual %0d", want.victim_row, got.victim_row);
            err_count++;
        end
        if (got.answer !== want.answer) begin
            $error("answer: expected %0d actual %0d", want.answer, got.answer);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) check_rsp(o_data);
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_req(trdt_pkg::t_req r);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        exp_rsp_q.push_back(predict_rsp(r));
    endtask

    task automatic send_op(logic [3:0] kind, int col, int row);
        trdt_pkg::t_req r;
        r.kind = kind;
        r.tile_col = 5'(col);
        r.tile_row = 5'(row);
        send_req(r);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (exp_rsp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] index, int unsigned value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= 11'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            trdt_pkg::CFG_GRID_WIDTH:  cfg_w = value & 32'h3F;
            trdt_pkg::CFG_GRID_HEIGHT: cfg_h = value & 32'h3F;
            default:                   cfg_lim = value & 32'h7FF;
        endcase
    endtask

    task automatic set_grid(int unsigned w, int unsigned h, int unsigned lim);
        cfg_write(trdt_pkg::CFG_GRID_WIDTH, w);
        cfg_write(trdt_pkg::CFG_GRID_HEIGHT, h);
        cfg_write(trdt_pkg::CFG_RES_LIMIT, lim);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin gap_pct = 0; stall_pct = 0; end
            1: begin gap_pct = 57; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 57; end
            default: begin gap_pct = 23; stall_pct = 23; end
        endcase
    endtask

    function automatic trdt_pkg::t_req rand_req();
        trdt_pkg::t_req r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) r.kind = 4'($urandom_range(trdt_pkg::K_CLEAR_ALL, trdt_pkg::K_CLEAR_ALL_D));
        else if (pick < 6) r.kind = 4'($urandom_range(11, 15));
        else if (pick < 40) r.kind = trdt_pkg::K_ACCESS;
        else if (pick < 55) r.kind = trdt_pkg::K_LOCK;
        else if (pick < 62) r.kind = trdt_pkg::K_MARK_DIRTY;
        else if (pick < 69) r.kind = trdt_pkg::K_CLEAR_DIRTY;
        else if (pick < 77) r.kind = trdt_pkg::K_QUERY_DIRTY;
        else if (pick < 84) r.kind = trdt_pkg::K_RESTORE_EMPTY;
        else if (pick < 90) r.kind = trdt_pkg::K_RESTORE_FULL;
        else r.kind = trdt_pkg::K_QUERY_RES;
        if ($urandom_range(0, 99) < 85) begin
            r.tile_col = 5'($urandom_range(0, cfg_w - 1));
            r.tile_row = 5'($urandom_range(0, cfg_h - 1));
        end else begin
            r.tile_col = 5'($urandom_range(0, 31));
            r.tile_row = 5'($urandom_range(0, 31));
        end
        return r;
    endfunction

    task automatic test_directed();
        set_grid(4, 4, 2);
        send_op(trdt_pkg::K_ACCESS, 0, 0);
        send_op(trdt_pkg::K_ACCESS, 1, 0);
        send_op(trdt_pkg::K_LOCK, 2, 0);
        send_op(trdt_pkg::K_QUERY_DIRTY, 0, 0);
        send_op(trdt_pkg::K_QUERY_RES, 1, 0);
        send_op(trdt_pkg::K_LOCK, 1, 0);
        send_op(trdt_pkg::K_ACCESS, 3, 3);
        send_op(trdt_pkg::K_MARK_DIRTY, 1, 1);
        send_op(trdt_pkg::K_MARK_DIRTY, 3, 3);
        send_op(trdt_pkg::K_CLEAR_DIRTY, 3, 3);
        send_op(trdt_pkg::K_QUERY_DIRTY, 1, 1);
        send_op(trdt_pkg::K_RESTORE_EMPTY, 2, 0);
        send_op(trdt_pkg::K_ACCESS, 4, 0);
        send_op(trdt_pkg::K_ACCESS, 0, 31);
        send_op(4'd15, 0, 0);
        send_op(4'd11, 31, 31);
        send_op(trdt_pkg::K_MARK_ALL, 0, 0);
        send_op(trdt_pkg::K_ACCESS, 2, 2);
        send_op(trdt_pkg::K_CLEAR_ALL_D, 0, 0);
        send_op(trdt_pkg::K_CLEAR_ALL, 31, 31);
        send_op(trdt_pkg::K_QUERY_DIRTY, 3, 3);
        set_grid(32, 32, 0);
        send_op(trdt_pkg::K_ACCESS, 31, 31);
        send_op(trdt_pkg::K_ACCESS, 0, 0);
        set_grid(1, 1, 1024);
        send_op(trdt_pkg::K_RESTORE_FULL, 0, 0);
        send_op(trdt_pkg::K_ACCESS, 0, 0);
        drain();
    endtask

    task automatic test_random_phase(int unsigned w, int unsigned h, int unsigned lim,
                                     int mode, int count);
        set_grid(w, h, lim);
        set_idling(mode);
        repeat (count) send_req(rand_req());
        drain();
    endtask

    task automatic test_backpressure();
        set_grid(8, 8, 1024);
        set_idling(0);
        hold_left = 400;
        repeat (30) send_req(rand_req());
        drain();
    endtask

    initial begin
        stamp_ctr = '0;
        res_count = 0;
        cap_raised = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(3, 3, 4, 0, 80);
        test_random_phase(32, 32, 1024, 1, 80);
        test_random_phase(1, 1, 1, 2, 60);
        test_backpressure();
        test_random_phase(5, 7, 20, 3, 90);
        test_random_phase(32, 1, 3, 0, 80);
        test_random_phase(2, 3, 1024, 2, 80);
        test_random_phase(6, 4, 10, 1, 80);
        set_idling(0);
        drain();
        repeat (50) @(posedge i_clk);
        if (err_count == 0 && exp_rsp_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
design/trdt_pkg.sv
design/tile_residency_dirty_tracker_core.sv
verif/testbench.sv
